// ===== rtl/core/qtu_pkg.sv =====
// Shared types and constants for the quoted token unescaper.
package qtu_pkg;

   parameter int unsigned DEF_MAX_TOKEN_BYTES = 255;

   typedef enum logic [2:0] {
      MODE_GAP   = 3'd0,
      MODE_WORD  = 3'd1,
      MODE_QUOTE = 3'd2,
      MODE_ESC   = 3'd3,
      MODE_HEX0  = 3'd4,
      MODE_HEX   = 3'd5,
      MODE_OCT   = 3'd6,
      MODE_DROP  = 3'd7
   } mode_type;

   typedef enum logic [2:0] {
      KIND_DATA   = 3'd0,
      KIND_DONE   = 3'd1,
      KIND_NONE   = 3'd2,
      KIND_LONG   = 3'd3,
      KIND_OPEN   = 3'd4,
      KIND_BADESC = 3'd5
   } kind_type;

   typedef struct packed {
      mode_type   mode;
      logic [7:0] esc_value;
      logic [1:0] oct_seen;
   } parse_state_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic [7:0] length;
      logic       line_end;
      logic       last;
   } result_type;

endpackage

// ===== rtl/core/qtu_decode.sv =====
// Per-byte parse step: next state and up to two results for one line byte.
module qtu_decode #(
   parameter int unsigned MAX_TOKEN_BYTES = qtu_pkg::DEF_MAX_TOKEN_BYTES,
   localparam int unsigned CNT_W = $clog2(MAX_TOKEN_BYTES + 1)
) (
   input  logic [7:0]                 line_byte,
   input  qtu_pkg::parse_state_type   state_cur,
   input  logic [CNT_W-1:0]           count_cur,
   output qtu_pkg::parse_state_type   state_nxt,
   output logic [CNT_W-1:0]           count_nxt,
   output qtu_pkg::result_type        res [2],
   output logic [1:0]                 res_num
);
   import qtu_pkg::*;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_SEVEN  = 8'h37;
   localparam logic [7:0] CH_X      = 8'h78;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TOKEN_BYTES);

   // {valid, value}
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] d;
      d = 5'd0;
      if (b >= 8'h30 && b <= 8'h39)      d = {1'b1, 4'(b - 8'h30)};
      else if (b >= 8'h41 && b <= 8'h46) d = {1'b1, 4'(b - 8'h37)};
      else if (b >= 8'h61 && b <= 8'h66) d = {1'b1, 4'(b - 8'h57)};
      return d;
   endfunction

   function automatic result_type mk(input kind_type k, input logic [7:0] d,
                                     input logic [7:0] len, input logic le);
      result_type r;
      r.kind     = k;
      r.data     = d;
      r.length   = (k == KIND_NONE) ? 8'd0 : len;
      r.line_end = le;
      r.last     = 1'b0;
      return r;
   endfunction

   parse_state_type  st;
   logic [CNT_W-1:0] cnt;
   logic [1:0]       n;
   result_type       r [2];
   logic             do_quoted;
   logic [4:0]       hd;
   logic             is_oct;
   logic [7:0]       lit;
   logic [7:0]       b;

   always_comb begin
      b         = line_byte;
      st        = state_cur;
      cnt       = count_cur;
      n         = 2'd0;
      r[0]      = '0;
      r[1]      = '0;
      do_quoted = 1'b0;
      hd        = hex_digit(b);
      is_oct    = (b >= CH_ZERO) && (b <= CH_SEVEN);
      lit       = b;

      unique case (state_cur.mode)
         MODE_GAP: begin
            cnt = '0;
            if (b == CH_NUL) begin
               r[n[0]] = mk(KIND_NONE, 8'd0, 8'(cnt), 1'b1);
               n = n + 2'd1;
            end else if (b == CH_QUOTE) begin
               st.mode = MODE_QUOTE;
            end else if (b != CH_SPACE) begin
               // count is zero here and the limit is at least one
               cnt = cnt + 1'b1;
               st.mode = MODE_WORD;
               r[n[0]] = mk(KIND_DATA, b, 8'(cnt), 1'b0);
               n = n + 2'd1;
            end
         end
         MODE_WORD: begin
            if (b == CH_NUL || b == CH_SPACE) begin
               r[n[0]] = mk(KIND_DONE, 8'd0, 8'(cnt), b == CH_NUL);
               n = n + 2'd1;
               st.mode = MODE_GAP;
            end else if (b == CH_QUOTE) begin
               st.mode = MODE_QUOTE;
            end else if (cnt >= CNT_MAX) begin
               r[n[0]] = mk(KIND_LONG, 8'd0, 8'(cnt), 1'b0);
               n = n + 2'd1;
               st.mode = MODE_DROP;
            end else begin
               cnt = cnt + 1'b1;
               r[n[0]] = mk(KIND_DATA, b, 8'(cnt), 1'b0);
               n = n + 2'd1;
            end
         end
         MODE_QUOTE: begin
            do_quoted = 1'b1;
         end
         MODE_ESC: begin
            st.mode = MODE_QUOTE;
            if (b == CH_NUL) begin
               cnt = cnt + 1'b1;
               r[0] = mk(KIND_DATA, CH_BSLASH, 8'(cnt), 1'b0);
               r[1] = mk(KIND_OPEN, 8'd0, 8'(cnt), 1'b1);
               n = 2'd2;
               st.mode = MODE_GAP;
            end else if (b == CH_X) begin
               st.esc_value = 8'd0;
               st.mode = MODE_HEX0;
            end else if (is_oct) begin
               st.esc_value = 8'(b - CH_ZERO);
               st.oct_seen = 2'd1;
               st.mode = MODE_OCT;
            end else begin
               priority case (b)
                  8'h6E:   lit = 8'd10;
                  8'h74:   lit = 8'd9;
                  8'h72:   lit = 8'd13;
                  8'h61:   lit = 8'd7;
                  8'h62:   lit = 8'd8;
                  8'h66:   lit = 8'd12;
                  8'h76:   lit = 8'd11;
                  default: lit = b;
               endcase
               cnt = cnt + 1'b1;
               r[n[0]] = mk(KIND_DATA, lit, 8'(cnt), 1'b0);
               n = n + 2'd1;
            end
         end
         MODE_HEX0: begin
            if (hd[4]) begin
               st.esc_value = {4'd0, hd[3:0]};
               st.mode = MODE_HEX;
            end else begin
               r[n[0]] = mk(KIND_BADESC, 8'd0, 8'(cnt), b == CH_NUL);
               n = n + 2'd1;
               st.mode = (b == CH_NUL) ? MODE_GAP : MODE_DROP;
            end
         end
         MODE_HEX: begin
            if (hd[4]) begin
               st.esc_value = {state_cur.esc_value[3:0], hd[3:0]};
            end else begin
               st.oct_seen = 2'd0;
               if (st.esc_value == 8'd0) begin
                  r[n[0]] = mk(KIND_BADESC, 8'd0, 8'(cnt), b == CH_NUL);
                  n = n + 2'd1;
                  st.mode = (b == CH_NUL) ? MODE_GAP : MODE_DROP;
               end else begin
                  cnt = cnt + 1'b1;
                  r[n[0]] = mk(KIND_DATA, st.esc_value, 8'(cnt), 1'b0);
                  n = n + 2'd1;
                  st.mode = MODE_QUOTE;
                  do_quoted = 1'b1;
               end
            end
         end
         MODE_OCT: begin
            if (is_oct) begin
               st.esc_value = {state_cur.esc_value[4:0], b[2:0]};
               st.oct_seen = state_cur.oct_seen + 2'd1;
               if (st.oct_seen == 2'd3) begin
                  // third digit closes the escape, no terminator byte
                  st.oct_seen = 2'd0;
                  if (st.esc_value == 8'd0) begin
                     r[n[0]] = mk(KIND_BADESC, 8'd0, 8'(cnt), 1'b0);
                     n = n + 2'd1;
                     st.mode = MODE_DROP;
                  end else begin
                     cnt = cnt + 1'b1;
                     r[n[0]] = mk(KIND_DATA, st.esc_value, 8'(cnt), 1'b0);
                     n = n + 2'd1;
                     st.mode = MODE_QUOTE;
                  end
               end
            end else begin
               st.oct_seen = 2'd0;
               if (st.esc_value == 8'd0) begin
                  r[n[0]] = mk(KIND_BADESC, 8'd0, 8'(cnt), b == CH_NUL);
                  n = n + 2'd1;
                  st.mode = (b == CH_NUL) ? MODE_GAP : MODE_DROP;
               end else begin
                  cnt = cnt + 1'b1;
                  r[n[0]] = mk(KIND_DATA, st.esc_value, 8'(cnt), 1'b0);
                  n = n + 2'd1;
                  st.mode = MODE_QUOTE;
                  do_quoted = 1'b1;
               end
            end
         end
         MODE_DROP: begin
            if (b == CH_NUL) begin
               cnt = '0;
               r[n[0]] = mk(KIND_NONE, 8'd0, 8'(cnt), 1'b1);
               n = n + 2'd1;
               st.mode = MODE_GAP;
            end
         end
      endcase

      // ordinary byte inside quotes, possibly after a numeric escape
      if (do_quoted) begin
         if (b == CH_NUL) begin
            r[n[0]] = mk(KIND_OPEN, 8'd0, 8'(cnt), 1'b1);
            n = n + 2'd1;
            st.mode = MODE_GAP;
         end else if (b == CH_QUOTE) begin
            st.mode = MODE_WORD;
         end else if (cnt >= CNT_MAX) begin
            r[n[0]] = mk(KIND_LONG, 8'd0, 8'(cnt), 1'b0);
            n = n + 2'd1;
            st.mode = MODE_DROP;
         end else if (b == CH_BSLASH) begin
            st.mode = MODE_ESC;
         end else begin
            cnt = cnt + 1'b1;
            r[n[0]] = mk(KIND_DATA, b, 8'(cnt), 1'b0);
            n = n + 2'd1;
         end
      end

      if (n == 2'd1) r[0].last = 1'b1;
      if (n == 2'd2) r[1].last = 1'b1;

      state_nxt = st;
      count_nxt = cnt;
      res       = r;
      res_num   = n;
   end

endmodule

// ===== rtl/core/quoted_token_unescaper.sv =====
// Top level of the quoted token unescaper: parse state and result queue.
// A taken byte's results are registered into the result queue; rsp_ offers its head.
// Throughput: one byte per cycle while req_stall is low; two results of one byte
//   leave in turn; the single result port and the 3-entry queue set the rate.
// Reset (synchronous, active high): parser between tokens, count and escape
//   state cleared, result queue emptied.
module quoted_token_unescaper #(
   parameter int unsigned MAX_TOKEN_BYTES = qtu_pkg::DEF_MAX_TOKEN_BYTES
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_line_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_result_kind,
   output logic [7:0] rsp_data_byte,
   output logic [7:0] rsp_token_length,
   output logic       rsp_line_end,
   output logic       rsp_last_of_item
);
   import qtu_pkg::*;

   localparam int unsigned CNT_W = $clog2(MAX_TOKEN_BYTES + 1);
   localparam int unsigned Q_DEPTH = 3;

   // parser state, advanced only on an accepted input transaction
   parse_state_type  state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // result queue, head always at entry 0
   result_type q_ff [Q_DEPTH];
   result_type q_in [Q_DEPTH];
   logic [1:0] q_cnt_ff, q_cnt_in;

   result_type dec_res [2];
   logic [1:0] dec_num;
   logic       req_accept;
   logic       rsp_pop;
   logic [1:0] after_pop;

   qtu_decode #(
      .MAX_TOKEN_BYTES(MAX_TOKEN_BYTES)
   ) u_decode (
      .line_byte (req_line_byte),
      .state_cur (state_ff),
      .count_cur (count_ff),
      .state_nxt (state_in),
      .count_nxt (count_in),
      .res       (dec_res),
      .res_num   (dec_num)
   );

   // output side
   assign rsp_valid        = (q_cnt_ff != 2'd0);
   assign rsp_pop          = rsp_valid && !rsp_stall;
   assign rsp_result_kind  = q_ff[0].kind;
   assign rsp_data_byte    = q_ff[0].data;
   assign rsp_token_length = q_ff[0].length;
   assign rsp_line_end     = q_ff[0].line_end;
   assign rsp_last_of_item = q_ff[0].last;

   // a new byte needs room for two results once this cycle's pop is done,
   // so a waiting result does not hold off the input
   assign after_pop  = q_cnt_ff - {1'b0, rsp_pop};
   assign req_stall  = (after_pop > 2'd1);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      for (int i = 0; i < Q_DEPTH; i++) begin
         if (rsp_pop && i < Q_DEPTH - 1) q_in[i] = q_ff[i + 1];
         else                            q_in[i] = q_ff[i];
         if (req_accept && dec_num != 2'd0 && 2'(i) == after_pop)
            q_in[i] = dec_res[0];
         if (req_accept && dec_num == 2'd2 && 2'(i) == 2'(after_pop + 2'd1))
            q_in[i] = dec_res[1];
      end
      q_cnt_in = after_pop + (req_accept ? dec_num : 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode      <= MODE_GAP;
         state_ff.esc_value <= 8'd0;
         state_ff.oct_seen  <= 2'd0;
         count_ff           <= '0;
         q_cnt_ff           <= 2'd0;
      end else begin
         if (req_accept) begin
            state_ff <= state_in;
            count_ff <= count_in;
         end
         q_cnt_ff <= q_cnt_in;
      end
   end

   // queue payload needs no reset
   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

`ifndef SYNTHESIS
   // a line-closing result is always the final one for its byte
   a_line_end_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_end |-> rsp_last_of_item)
      else $error("line end result not last of its byte");

   // "no token" carries zero length and closes the line
   a_none_shape : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_NONE |->
         rsp_token_length == 8'd0 && rsp_line_end)
      else $error("malformed no-token result");

   // a byte with no results leaves the queue untouched when nothing drains
   a_silent_byte : assert property (@(posedge clock) disable iff (reset)
      req_accept && dec_num == 2'd0 && !rsp_pop |=> q_cnt_ff == $past(q_cnt_ff))
      else $error("queue changed on a silent byte");

   // both results of a two-result byte land in the queue
   a_two_results : assert property (@(posedge clock) disable iff (reset)
      req_accept && dec_num == 2'd2 |=> q_cnt_ff >= 2'd2)
      else $error("second result lost");
`endif

endmodule

// ===== test/tb.sv =====
// Testbench for the quoted token unescaper: queued line bytes, inline parser model, result check.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import qtu_pkg::*;

   // Token limit of the instance under test (default parameter value).
   localparam int unsigned MAX_BYTES  = DEF_MAX_TOKEN_BYTES;
   // Receiver hold-off used to back the block up until it stalls its input.
   localparam int          LONG_HOLD  = 80;
   // Quiet cycles after the last result.
   localparam int          DRAIN      = 10;
   // Bound on waiting for outstanding results before calling them lost.
   localparam int          RESULT_WAIT = 5000;

   // Bytes with a meaning to the parser.
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_X      = 8'h78;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_SEVEN  = 8'h37;

   // ------------------------------------------------------------------
   // Clock, reset and the block's ports. Every input starts at a known value.
   // ------------------------------------------------------------------
   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_line_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_result_kind;
   logic [7:0] rsp_data_byte;
   logic [7:0] rsp_token_length;
   logic       rsp_line_end;
   logic       rsp_last_of_item;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   quoted_token_unescaper u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_line_byte    (req_line_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_token_length (rsp_token_length),
      .rsp_line_end     (rsp_line_end),
      .rsp_last_of_item (rsp_last_of_item)
   );

   // ------------------------------------------------------------------
   // Shared bookkeeping
   // ------------------------------------------------------------------
   logic [7:0]  line_bytes[$];      // bytes waiting to be offered on req_
   result_type  token_results[$];   // results the parser model says are owed
   int unsigned items_queued = 0;
   int unsigned items_taken  = 0;
   int unsigned results_seen = 0;
   int unsigned mismatches   = 0;
   int          sender_idle_pct   = 31;
   int          receiver_idle_pct = 54;
   int          hold_asked  = 0;    // bumped by the sequencer to request a hold-off
   int          hold_served = 0;
   int          hold_left   = 0;

   task automatic report_mismatch(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                                   results_seen, name, got, want));
   endtask

   // ------------------------------------------------------------------
   // Parser model: own copy of the mode, escape accumulator, octal digit
   // count and decoded byte count, stepped once per accepted transaction.
   // ------------------------------------------------------------------
   mode_type    p_mode  = MODE_GAP;
   logic [7:0]  p_esc   = 8'h00;
   logic [1:0]  p_oct   = 2'd0;
   int unsigned p_count = 0;
   int unsigned step_results;

   function automatic void push_result(kind_type kind, logic [7:0] data, logic line_end);
      result_type r;
      r.kind     = kind;
      r.data     = data;
      r.length   = (kind == KIND_NONE) ? 8'd0 : p_count[7:0];
      r.line_end = line_end;
      r.last     = 1'b0;
      token_results.push_back(r);
      step_results++;
   endfunction

   function automatic void put_token_byte(logic [7:0] v);
      p_count++;
      push_result(KIND_DATA, v, 1'b0);
   endfunction

   // Error: a NUL closes the line at once, anything else starts discarding.
   function automatic void abort_token(kind_type kind, logic [7:0] b);
      push_result(kind, 8'h00, b == CH_NUL);
      p_mode = (b == CH_NUL) ? MODE_GAP : MODE_DROP;
   endfunction

   function automatic void quoted_char(logic [7:0] b);
      if (b == CH_NUL) begin
         push_result(KIND_OPEN, 8'h00, 1'b1);
         p_mode = MODE_GAP;
      end else if (b == CH_QUOTE) begin
         p_mode = MODE_WORD;
      end else if (p_count >= MAX_BYTES) begin
         // limit is tested at the byte starting the item, backslash included
         abort_token(KIND_LONG, b);
      end else if (b == CH_BSLASH) begin
         p_mode = MODE_ESC;
      end else begin
         put_token_byte(b);
      end
   endfunction

   // End of a hex or octal escape; has_term says byte b ended it and still needs handling.
   function automatic void close_number(logic [7:0] b, logic has_term);
      p_oct = 2'd0;
      if (p_esc == 8'h00) begin
         abort_token(KIND_BADESC, has_term ? b : 8'h01);
      end else begin
         put_token_byte(p_esc);
         p_mode = MODE_QUOTE;
         if (has_term)
            quoted_char(b);
      end
   endfunction

   function automatic logic [4:0] hex_value(logic [7:0] b);
      if (b >= "0" && b <= "9") return 5'(b - "0");
      if (b >= "A" && b <= "F") return 5'(b - "A" + 8'd10);
      if (b >= "a" && b <= "f") return 5'(b - "a" + 8'd10);
      return 5'd16;
   endfunction

   function automatic void parse_line_byte(logic [7:0] b);
      logic [4:0] d;
      logic [7:0] v;
      step_results = 0;
      case (p_mode)
         MODE_GAP: begin
            p_count = 0;
            if (b == CH_NUL) begin
               push_result(KIND_NONE, 8'h00, 1'b1);
            end else if (b == CH_QUOTE) begin
               p_mode = MODE_QUOTE;
            end else if (b != CH_SPACE) begin
               p_mode = MODE_WORD;
               if (p_count >= MAX_BYTES)
                  abort_token(KIND_LONG, b);
               else
                  put_token_byte(b);
            end
         end
         MODE_WORD: begin
            if (b == CH_NUL || b == CH_SPACE) begin
               push_result(KIND_DONE, 8'h00, b == CH_NUL);
               p_mode = MODE_GAP;
            end else if (b == CH_QUOTE) begin
               p_mode = MODE_QUOTE;
            end else if (p_count >= MAX_BYTES) begin
               abort_token(KIND_LONG, b);
            end else begin
               put_token_byte(b);
            end
         end
         MODE_QUOTE: quoted_char(b);
         MODE_ESC: begin
            p_mode = MODE_QUOTE;
            if (b == CH_NUL) begin
               // trailing backslash is kept as a literal, then the quote is left open
               put_token_byte(CH_BSLASH);
               push_result(KIND_OPEN, 8'h00, 1'b1);
               p_mode = MODE_GAP;
            end else if (b == CH_X) begin
               p_esc  = 8'h00;
               p_mode = MODE_HEX0;
            end else if (b >= CH_ZERO && b <= CH_SEVEN) begin
               p_esc  = {5'd0, b[2:0]};
               p_oct  = 2'd1;
               p_mode = MODE_OCT;
            end else begin
               case (b)
                  "n":     v = 8'd10;
                  "t":     v = 8'd9;
                  "r":     v = 8'd13;
                  "a":     v = 8'd7;
                  "b":     v = 8'd8;
                  "f":     v = 8'd12;
                  "v":     v = 8'd11;
                  default: v = b;
               endcase
               put_token_byte(v);
            end
         end
         MODE_HEX0: begin
            d = hex_value(b);
            if (d < 5'd16) begin
               p_esc  = {4'h0, d[3:0]};
               p_mode = MODE_HEX;
            end else begin
               abort_token(KIND_BADESC, b);
            end
         end
         MODE_HEX: begin
            d = hex_value(b);
            if (d < 5'd16)
               p_esc = {p_esc[3:0], d[3:0]};
            else
               close_number(b, 1'b1);
         end
         MODE_OCT: begin
            if (b >= CH_ZERO && b <= CH_SEVEN) begin
               p_esc = {p_esc[4:0], b[2:0]};
               p_oct = p_oct + 2'd1;
               if (p_oct == 2'd3)
                  close_number(b, 1'b0);
            end else begin
               close_number(b, 1'b1);
            end
         end
         default: begin
            // discarding after an error until the line ends
            if (b == CH_NUL) begin
               p_count = 0;
               push_result(KIND_NONE, 8'h00, 1'b1);
               p_mode = MODE_GAP;
            end
         end
      endcase
      if (step_results > 0)
         token_results[token_results.size() - 1].last = 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // Driver: offers queued bytes, idles at random, holds a stalled payload.
   // The model is stepped here, at the edge where the transaction completes.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid     <= 1'b0;
         req_line_byte <= 8'h00;
      end else begin
         if (req_valid && !req_stall) begin
            parse_line_byte(req_line_byte);
            items_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (line_bytes.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               req_valid     <= 1'b1;
               req_line_byte <= line_bytes.pop_front();
            end else begin
               req_valid     <= 1'b0;
               req_line_byte <= 8'($urandom_range(0, 255));
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver stall: random back-pressure, or a long counted hold-off
   // when the sequencer asks for one.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_asked) begin
         hold_served <= hold_asked;
         hold_left   <= LONG_HOLD;
         rsp_stall   <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
      end
   end

   // ------------------------------------------------------------------
   // Monitor: each accepted result against the oldest owed one.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (token_results.size() == 0) begin
            report_mismatch($sformatf("result %0d (kind %0h) with nothing owed",
                                      results_seen, rsp_result_kind));
         end else begin
            want = token_results.pop_front();
            check_field("result_kind",  rsp_result_kind,  want.kind);
            check_field("data_byte",    rsp_data_byte,    want.data);
            check_field("token_length", rsp_token_length, want.length);
            check_field("line_end",     rsp_line_end,     want.line_end);
            check_field("last_of_item", rsp_last_of_item, want.last);
         end
         results_seen++;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus builders
   // ------------------------------------------------------------------
   task automatic queue_byte(logic [7:0] b);
      line_bytes.push_back(b);
      items_queued++;
   endtask

   // byte allowed inside an unquoted word
   function automatic logic [7:0] word_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255)); while (b == CH_SPACE || b == CH_QUOTE);
      return b;
   endfunction

   // plain byte inside quotes
   function automatic logic [7:0] quoted_plain();
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
      return b;
   endfunction

   task automatic queue_quoted_element();
      logic [7:0] b;
      int         d;
      case ($urandom_range(0, 5))
         0, 1: queue_byte(quoted_plain());
         2: begin
            queue_byte(CH_BSLASH);
            case ($urandom_range(0, 7))
               0: queue_byte("n");
               1: queue_byte("t");
               2: queue_byte("r");
               3: queue_byte("a");
               4: queue_byte("b");
               5: queue_byte("f");
               6: queue_byte("v");
               default: begin
                  // any byte but x or an octal digit; outside n, t, r, a, b, f and v it stands for itself
                  do b = 8'($urandom_range(1, 255));
                  while (b == CH_X || (b >= CH_ZERO && b <= CH_SEVEN));
                  queue_byte(b);
               end
            endcase
         end
         3, 4: begin
            // hex escape; no digit at all now and then
            queue_byte(CH_BSLASH);
            queue_byte(CH_X);
            repeat ($urandom_range(0, 3)) begin
               d = int'($urandom_range(0, 15));
               if (d < 10)
                  queue_byte(CH_ZERO + 8'(d));
               else
                  queue_byte(8'(($urandom_range(0, 1) ? "a" : "A") + d - 10));
            end
         end
         default: begin
            queue_byte(CH_BSLASH);
            repeat ($urandom_range(1, 3)) queue_byte(CH_ZERO + 8'($urandom_range(0, 7)));
         end
      endcase
   endtask

   // Mostly well-formed lines of words and quoted segments, some left with
   // an open quote or a trailing backslash, some plain noise.
   task automatic queue_random_line();
      int style;
      int tokens;
      int segs;
      style = $urandom_range(0, 99);
      if (style < 12) begin
         repeat ($urandom_range(1, 8)) queue_byte(8'($urandom_range(0, 255)));
         queue_byte(CH_NUL);
      end else begin
         repeat ($urandom_range(0, 2)) queue_byte(CH_SPACE);
         tokens = $urandom_range(0, 4);
         for (int t = 0; t < tokens; t++) begin
            if (t > 0)
               repeat ($urandom_range(1, 3)) queue_byte(CH_SPACE);
            segs = $urandom_range(1, 3);
            for (int s = 0; s < segs; s++) begin
               if ($urandom_range(0, 1)) begin
                  repeat ($urandom_range(1, 6)) queue_byte(word_byte());
               end else begin
                  queue_byte(CH_QUOTE);
                  repeat ($urandom_range(0, 5)) queue_quoted_element();
                  queue_byte(CH_QUOTE);
               end
            end
         end
         if (style < 24) begin
            queue_byte(CH_QUOTE);
            repeat ($urandom_range(0, 3)) queue_quoted_element();
            if ($urandom_range(0, 1))
               queue_byte(CH_BSLASH);
         end else begin
            repeat ($urandom_range(0, 2)) queue_byte(CH_SPACE);
         end
         queue_byte(CH_NUL);
      end
   endtask

   // Waits for every queued transaction and every owed result, then lets
   // the block settle.
   task automatic wait_for_quiet();
      int spent;
      spent = 0;
      while (items_taken != items_queued)
         @(posedge clock);
      while (token_results.size() != 0 && spent < RESULT_WAIT) begin
         @(posedge clock);
         spent++;
      end
      repeat (DRAIN) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   initial begin
      logic [7:0] directed[$];
      // Directed lines:
      //   empty line;
      //   smallest and largest word bytes, token ended by a space, then line end between tokens;
      //   hex escape ended by an ordinary quoted byte (two results from one byte);
      //   octal escape of value zero ended by the line end;
      //   backslash as the last byte of the line;
      //   hex escape with no digit, discarded tail.
      directed = '{CH_NUL,
                   8'h01, 8'hFF, CH_SPACE, CH_NUL,
                   CH_QUOTE, CH_BSLASH, CH_X, "4", "1", "g", CH_QUOTE, CH_NUL,
                   CH_QUOTE, CH_BSLASH, CH_ZERO, CH_NUL,
                   CH_QUOTE, CH_BSLASH, CH_NUL,
                   CH_QUOTE, CH_BSLASH, CH_X, "z", CH_NUL};

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Phase one: sender idles less than the receiver.
      sender_idle_pct   = 31;
      receiver_idle_pct = 54;
      foreach (directed[i]) queue_byte(directed[i]);
      // unquoted word pushed past the limit
      repeat (MAX_BYTES) queue_byte(word_byte());
      queue_byte(word_byte());
      repeat (3) queue_byte(8'($urandom_range(1, 255)));
      queue_byte(CH_NUL);
      while (items_queued < 380) queue_random_line();
      // sender pauses until everything owed has come back
      wait_for_quiet();

      // Phase two: roles swapped.
      sender_idle_pct   = 54;
      receiver_idle_pct = 31;
      // quoted token at the limit, tested on the backslash of the next escape
      queue_byte(CH_QUOTE);
      repeat (MAX_BYTES - 1) queue_byte(quoted_plain());
      queue_byte(CH_BSLASH);
      queue_byte("t");
      queue_byte(CH_BSLASH);
      queue_byte("n");
      queue_byte(CH_NUL);
      while (items_queued < 720) queue_random_line();
      wait_for_quiet();

      // Phase three: no idling, plus one long receiver hold-off while the
      // sender keeps offering, so the result queue fills and req_stall rises.
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      while (items_queued < 845) queue_random_line();
      repeat (20) @(posedge clock);
      hold_asked++;
      wait_for_quiet();

      if (token_results.size() != 0)
         report_mismatch($sformatf("%0d results owed but never seen", token_results.size()));
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
